// ----- rtl/kuznyechik_block_encrypt_top_defines.svh -----
// Assertion helpers for the top-level RTL file.
`ifndef KUZNYECHIK_BLOCK_ENCRYPT_TOP_DEFINES_SVH
`define KUZNYECHIK_BLOCK_ENCRYPT_TOP_DEFINES_SVH

// Check that an implication holds on every clock edge outside reset.
`define KBE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication failed");

// Check that the consequent holds in the cycle after the antecedent.
`define KBE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- rtl/kbe_pkg.sv -----
package kbe_pkg;

  localparam int unsigned RoundCount = 10;
  localparam int unsigned NumBytes   = 16;
  localparam int unsigned LinSteps   = 16;
  localparam int unsigned ConstCount = 32;

  typedef logic [127:0] blk_t;
  typedef logic [7:0]   byte_t;
  typedef logic [3:0]   rnd_idx_t;
  typedef logic [4:0]   cnst_idx_t;
  typedef logic [1:0]   reg_idx_t;

  localparam reg_idx_t RegKey0 = 2'd0;
  localparam reg_idx_t RegKey1 = 2'd1;
  localparam reg_idx_t RegKey2 = 2'd2;
  localparam reg_idx_t RegKey3 = 2'd3;

  typedef enum logic [1:0] {
    StIdle,
    StExpand,
    StCrypt,
    StOut
  } state_e;

  // Shared datapath mode for the chain of byte cells.
  typedef struct packed {
    logic load;
    logic step;
  } lin_ctrl_t;

  function automatic byte_t pi_sbox(input byte_t a);
    byte_t r;
    case (a)
      8'h00: r = 8'hFC; 8'h01: r = 8'hEE; 8'h02: r = 8'hDD; 8'h03: r = 8'h11;
      8'h04: r = 8'hCF; 8'h05: r = 8'h6E; 8'h06: r = 8'h31; 8'h07: r = 8'h16;
      8'h08: r = 8'hFB; 8'h09: r = 8'hC4; 8'h0A: r = 8'hFA; 8'h0B: r = 8'hDA;
      8'h0C: r = 8'h23; 8'h0D: r = 8'hC5; 8'h0E: r = 8'h04; 8'h0F: r = 8'h4D;
      8'h10: r = 8'hE9; 8'h11: r = 8'h77; 8'h12: r = 8'hF0; 8'h13: r = 8'hDB;
      8'h14: r = 8'h93; 8'h15: r = 8'h2E; 8'h16: r = 8'h99; 8'h17: r = 8'hBA;
      8'h18: r = 8'h17; 8'h19: r = 8'h36; 8'h1A: r = 8'hF1; 8'h1B: r = 8'hBB;
      8'h1C: r = 8'h14; 8'h1D: r = 8'hCD; 8'h1E: r = 8'h5F; 8'h1F: r = 8'hC1;
      8'h20: r = 8'hF9; 8'h21: r = 8'h18; 8'h22: r = 8'h65; 8'h23: r = 8'h5A;
      8'h24: r = 8'hE2; 8'h25: r = 8'h5C; 8'h26: r = 8'hEF; 8'h27: r = 8'h21;
      8'h28: r = 8'h81; 8'h29: r = 8'h1C; 8'h2A: r = 8'h3C; 8'h2B: r = 8'h42;
      8'h2C: r = 8'h8B; 8'h2D: r = 8'h01; 8'h2E: r = 8'h8E; 8'h2F: r = 8'h4F;
      8'h30: r = 8'h05; 8'h31: r = 8'h84; 8'h32: r = 8'h02; 8'h33: r = 8'hAE;
      8'h34: r = 8'hE3; 8'h35: r = 8'h6A; 8'h36: r = 8'h8F; 8'h37: r = 8'hA0;
      8'h38: r = 8'h06; 8'h39: r = 8'h0B; 8'h3A: r = 8'hED; 8'h3B: r = 8'h98;
      8'h3C: r = 8'h7F; 8'h3D: r = 8'hD4; 8'h3E: r = 8'hD3; 8'h3F: r = 8'h1F;
      8'h40: r = 8'hEB; 8'h41: r = 8'h34; 8'h42: r = 8'h2C; 8'h43: r = 8'h51;
      8'h44: r = 8'hEA; 8'h45: r = 8'hC8; 8'h46: r = 8'h48; 8'h47: r = 8'hAB;
      8'h48: r = 8'hF2; 8'h49: r = 8'h2A; 8'h4A: r = 8'h68; 8'h4B: r = 8'hA2;
      8'h4C: r = 8'hFD; 8'h4D: r = 8'h3A; 8'h4E: r = 8'hCE; 8'h4F: r = 8'hCC;
      8'h50: r = 8'hB5; 8'h51: r = 8'h70; 8'h52: r = 8'h0E; 8'h53: r = 8'h56;
      8'h54: r = 8'h08; 8'h55: r = 8'h0C; 8'h56: r = 8'h76; 8'h57: r = 8'h12;
      8'h58: r = 8'hBF; 8'h59: r = 8'h72; 8'h5A: r = 8'h13; 8'h5B: r = 8'h47;
      8'h5C: r = 8'h9C; 8'h5D: r = 8'hB7; 8'h5E: r = 8'h5D; 8'h5F: r = 8'h87;
      8'h60: r = 8'h15; 8'h61: r = 8'hA1; 8'h62: r = 8'h96; 8'h63: r = 8'h29;
      8'h64: r = 8'h10; 8'h65: r = 8'h7B; 8'h66: r = 8'h9A; 8'h67: r = 8'hC7;
      8'h68: r = 8'hF3; 8'h69: r = 8'h91; 8'h6A: r = 8'h78; 8'h6B: r = 8'h6F;
      8'h6C: r = 8'h9D; 8'h6D: r = 8'h9E; 8'h6E: r = 8'hB2; 8'h6F: r = 8'hB1;
      8'h70: r = 8'h32; 8'h71: r = 8'h75; 8'h72: r = 8'h19; 8'h73: r = 8'h3D;
      8'h74: r = 8'hFF; 8'h75: r = 8'h35; 8'h76: r = 8'h8A; 8'h77: r = 8'h7E;
      8'h78: r = 8'h6D; 8'h79: r = 8'h54; 8'h7A: r = 8'hC6; 8'h7B: r = 8'h80;
      8'h7C: r = 8'hC3; 8'h7D: r = 8'hBD; 8'h7E: r = 8'h0D; 8'h7F: r = 8'h57;
      8'h80: r = 8'hDF; 8'h81: r = 8'hF5; 8'h82: r = 8'h24; 8'h83: r = 8'hA9;
      8'h84: r = 8'h3E; 8'h85: r = 8'hA8; 8'h86: r = 8'h43; 8'h87: r = 8'hC9;
      8'h88: r = 8'hD7; 8'h89: r = 8'h79; 8'h8A: r = 8'hD6; 8'h8B: r = 8'hF6;
      8'h8C: r = 8'h7C; 8'h8D: r = 8'h22; 8'h8E: r = 8'hB9; 8'h8F: r = 8'h03;
      8'h90: r = 8'hE0; 8'h91: r = 8'h0F; 8'h92: r = 8'hEC; 8'h93: r = 8'hDE;
      8'h94: r = 8'h7A; 8'h95: r = 8'h94; 8'h96: r = 8'hB0; 8'h97: r = 8'hBC;
      8'h98: r = 8'hDC; 8'h99: r = 8'hE8; 8'h9A: r = 8'h28; 8'h9B: r = 8'h50;
      8'h9C: r = 8'h4E; 8'h9D: r = 8'h33; 8'h9E: r = 8'h0A; 8'h9F: r = 8'h4A;
      8'hA0: r = 8'hA7; 8'hA1: r = 8'h97; 8'hA2: r = 8'h60; 8'hA3: r = 8'h73;
      8'hA4: r = 8'h1E; 8'hA5: r = 8'h00; 8'hA6: r = 8'h62; 8'hA7: r = 8'h44;
      8'hA8: r = 8'h1A; 8'hA9: r = 8'hB8; 8'hAA: r = 8'h38; 8'hAB: r = 8'h82;
      8'hAC: r = 8'h64; 8'hAD: r = 8'h9F; 8'hAE: r = 8'h26; 8'hAF: r = 8'h41;
      8'hB0: r = 8'hAD; 8'hB1: r = 8'h45; 8'hB2: r = 8'h46; 8'hB3: r = 8'h92;
      8'hB4: r = 8'h27; 8'hB5: r = 8'h5E; 8'hB6: r = 8'h55; 8'hB7: r = 8'h2F;
      8'hB8: r = 8'h8C; 8'hB9: r = 8'hA3; 8'hBA: r = 8'hA5; 8'hBB: r = 8'h7D;
      8'hBC: r = 8'h69; 8'hBD: r = 8'hD5; 8'hBE: r = 8'h95; 8'hBF: r = 8'h3B;
      8'hC0: r = 8'h07; 8'hC1: r = 8'h58; 8'hC2: r = 8'hB3; 8'hC3: r = 8'h40;
      8'hC4: r = 8'h86; 8'hC5: r = 8'hAC; 8'hC6: r = 8'h1D; 8'hC7: r = 8'hF7;
      8'hC8: r = 8'h30; 8'hC9: r = 8'h37; 8'hCA: r = 8'h6B; 8'hCB: r = 8'hE4;
      8'hCC: r = 8'h88; 8'hCD: r = 8'hD9; 8'hCE: r = 8'hE7; 8'hCF: r = 8'h89;
      8'hD0: r = 8'hE1; 8'hD1: r = 8'h1B; 8'hD2: r = 8'h83; 8'hD3: r = 8'h49;
      8'hD4: r = 8'h4C; 8'hD5: r = 8'h3F; 8'hD6: r = 8'hF8; 8'hD7: r = 8'hFE;
      8'hD8: r = 8'h8D; 8'hD9: r = 8'h53; 8'hDA: r = 8'hAA; 8'hDB: r = 8'h90;
      8'hDC: r = 8'hCA; 8'hDD: r = 8'hD8; 8'hDE: r = 8'h85; 8'hDF: r = 8'h61;
      8'hE0: r = 8'h20; 8'hE1: r = 8'h71; 8'hE2: r = 8'h67; 8'hE3: r = 8'hA4;
      8'hE4: r = 8'h2D; 8'hE5: r = 8'h2B; 8'hE6: r = 8'h09; 8'hE7: r = 8'h5B;
      8'hE8: r = 8'hCB; 8'hE9: r = 8'h9B; 8'hEA: r = 8'h25; 8'hEB: r = 8'hD0;
      8'hEC: r = 8'hBE; 8'hED: r = 8'hE5; 8'hEE: r = 8'h6C; 8'hEF: r = 8'h52;
      8'hF0: r = 8'h59; 8'hF1: r = 8'hA6; 8'hF2: r = 8'h74; 8'hF3: r = 8'hD2;
      8'hF4: r = 8'hE6; 8'hF5: r = 8'hF4; 8'hF6: r = 8'hB4; 8'hF7: r = 8'hC0;
      8'hF8: r = 8'hD1; 8'hF9: r = 8'h66; 8'hFA: r = 8'hAF; 8'hFB: r = 8'hC2;
      8'hFC: r = 8'h39; 8'hFD: r = 8'h4B; 8'hFE: r = 8'h63; 8'hFF: r = 8'hB6;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t lin_coef(input logic [3:0] k);
    byte_t r;
    case (k)
      4'd0:  r = 8'd1;   4'd1:  r = 8'd148; 4'd2:  r = 8'd32;  4'd3:  r = 8'd133;
      4'd4:  r = 8'd16;  4'd5:  r = 8'd194; 4'd6:  r = 8'd192; 4'd7:  r = 8'd1;
      4'd8:  r = 8'd251; 4'd9:  r = 8'd1;   4'd10: r = 8'd192; 4'd11: r = 8'd194;
      4'd12: r = 8'd16;  4'd13: r = 8'd133; 4'd14: r = 8'd32;  4'd15: r = 8'd148;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // GF(2^8) multiply, modulus 0x1C3.
  function automatic byte_t gf_mul(input byte_t a, input byte_t b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int n = 0; n < 8; n++) begin
      if (b[n]) acc = acc ^ x;
      x = x[7] ? ((x << 1) ^ 8'hC3) : (x << 1);
    end
    return acc;
  endfunction

endpackage

// ----- rtl/kuznyechik_block_encrypt_top.sv -----
// A request is taken only in idle. Each block runs nine rounds (key read of two words,
// X and S load, 16 L shifts in the sixteen-cell chain, store) and a final XOR with the
// last round key; a new block is taken only after the previous result has been taken.
// A block after reset or a key write first runs the key expansion: 4 key writes,
// 32 Feistel steps (constant and data pass), 16 writes.
// Reset clears the key registers, control state and key-ready flag, not the key store.
`include "kuznyechik_block_encrypt_top_defines.svh"

module kuznyechik_block_encrypt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] plain_high_i,
  input  logic [63:0] plain_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] cipher_high_o,
  output logic [63:0] cipher_low_o
);

  // Phases within one LSX step.
  typedef enum logic [2:0] {
    PhRead,
    PhWait,
    PhLoad,
    PhShift,
    PhDone
  } phase_e;

  logic [63:0] key_q [4];
  logic        keys_ready_q, keys_ready_d;

  kbe_pkg::state_e state_q, state_d;
  phase_e          ph_q, ph_d;
  logic [3:0]      shift_q, shift_d;
  logic [4:0]      step_q, step_d;     // Feistel step or round index
  logic            sub_q, sub_d;       // constant pass vs data pass in expansion
  logic            wr_q, wr_d;         // set once the first two key pairs are stored
  logic [1:0]      wcnt_q, wcnt_d;

  kbe_pkg::blk_t   a1_q, a1_d, a0_q, a0_d, v_q, v_d, c_q, c_d;
  kbe_pkg::blk_t   rk_q, rk_d;
  kbe_pkg::blk_t   load_val;
  kbe_pkg::blk_t   chain_val;
  kbe_pkg::lin_ctrl_t lctrl;

  logic        ram_we;
  logic [4:0]  ram_waddr, ram_raddr;
  logic [63:0] ram_wdata, ram_rdata;
  logic        rd_hi_q, rd_hi_d;

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  kbe_ram #(.Width(64), .Depth(2 * kbe_pkg::RoundCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  kbe_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (lctrl),
    .load_i (load_val),
    .value_o(chain_val)
  );

  function automatic kbe_pkg::blk_t sub_all(input kbe_pkg::blk_t x);
    kbe_pkg::blk_t r;
    for (int k = 0; k < kbe_pkg::NumBytes; k++) r[8*k +: 8] = kbe_pkg::pi_sbox(x[8*k +: 8]);
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= '0;
      key_q[1] <= '0;
      key_q[2] <= '0;
      key_q[3] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        kbe_pkg::RegKey0: key_q[0] <= cfg_data_i;
        kbe_pkg::RegKey1: key_q[1] <= cfg_data_i;
        kbe_pkg::RegKey2: key_q[2] <= cfg_data_i;
        kbe_pkg::RegKey3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kbe_pkg::StIdle;
      ph_q         <= PhRead;
      shift_q      <= '0;
      step_q       <= '0;
      sub_q        <= 1'b0;
      wr_q         <= 1'b0;
      wcnt_q       <= '0;
      rd_hi_q      <= 1'b0;
      keys_ready_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      ph_q         <= ph_d;
      shift_q      <= shift_d;
      step_q       <= step_d;
      sub_q        <= sub_d;
      wr_q         <= wr_d;
      wcnt_q       <= wcnt_d;
      rd_hi_q      <= rd_hi_d;
      keys_ready_q <= keys_ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d;
    a0_q <= a0_d;
    v_q  <= v_d;
    c_q  <= c_d;
    rk_q <= rk_d;
  end

  always_comb begin
    state_d      = state_q;
    ph_d         = ph_q;
    shift_d      = shift_q;
    step_d       = step_q;
    sub_d        = sub_q;
    wr_d         = wr_q;
    wcnt_d       = wcnt_q;
    rd_hi_d      = rd_hi_q;
    keys_ready_d = keys_ready_q;
    a1_d = a1_q;
    a0_d = a0_q;
    v_d  = v_q;
    c_d  = c_q;
    rk_d = rk_q;
    lctrl     = '0;
    load_val  = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;

    case (state_q)
      kbe_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          v_d = {plain_high_i, plain_low_i};
          ph_d = PhRead;
          step_d = '0;
          if (!keys_ready_q) begin
            a1_d = {key_q[0], key_q[1]};
            a0_d = {key_q[2], key_q[3]};
            state_d = kbe_pkg::StExpand;
            sub_d = 1'b1;
            wr_d = 1'b0;
            wcnt_d = '0;
          end else begin
            state_d = kbe_pkg::StCrypt;
          end
        end
      end

      kbe_pkg::StExpand: begin
        // Store pairs 0/1 first (four words), then run the Feistel steps.
        if (!wr_q) begin
          ram_we = 1'b1;
          ram_waddr = {3'd0, wcnt_q};
          case (wcnt_q)
            2'd0: ram_wdata = a1_q[127:64];
            2'd1: ram_wdata = a1_q[63:0];
            2'd2: ram_wdata = a0_q[127:64];
            default: ram_wdata = a0_q[63:0];
          endcase
          wcnt_d = wcnt_q + 2'd1;
          if (wcnt_q == 2'd3) wr_d = 1'b1;
        end else begin
          case (ph_q)
            PhRead: begin
              // Constant pass builds C = L(step+1) in the chain; data pass loads S(a1 ^ C).
              lctrl.load = 1'b1;
              if (sub_q) begin
                load_val = 128'(step_q) + 128'd1;
              end else begin
                load_val = sub_all(a1_q ^ c_q);
              end
              shift_d = '0;
              ph_d = PhShift;
            end
            PhShift: begin
              lctrl.step = 1'b1;
              shift_d = shift_q + 4'd1;
              if (shift_q == 4'(kbe_pkg::LinSteps - 1)) ph_d = PhDone;
            end
            PhDone: begin
              if (sub_q) begin
                c_d = chain_val;
                sub_d = 1'b0;
                ph_d = PhRead;
              end else begin
                a1_d = chain_val ^ a0_q;
                a0_d = a1_q;
                sub_d = 1'b1;
                step_d = step_q + 5'd1;
                ph_d = (step_q[2:0] == 3'd7) ? PhWait : PhRead;
                wcnt_d = '0;
              end
            end
            PhWait: begin
              // Write the pair after every eighth step; the last pair sees the count wrap.
              ram_we = 1'b1;
              ram_waddr = {(step_q[4:3] == 2'd0) ? 3'd4 : {1'b0, step_q[4:3]}, 2'b00}
                          + {3'd0, wcnt_q};
              case (wcnt_q)
                2'd0: ram_wdata = a1_q[127:64];
                2'd1: ram_wdata = a1_q[63:0];
                2'd2: ram_wdata = a0_q[127:64];
                default: ram_wdata = a0_q[63:0];
              endcase
              wcnt_d = wcnt_q + 2'd1;
              if (wcnt_q == 2'd3) begin
                if (step_q == 5'd0) begin
                  keys_ready_d = 1'b1;
                  state_d = kbe_pkg::StCrypt;
                  step_d = '0;
                end
                ph_d = PhRead;
              end
            end
            default: ph_d = PhRead;
          endcase
        end
      end

      kbe_pkg::StCrypt: begin
        case (ph_q)
          PhRead: begin
            ram_raddr = {step_q[3:0], 1'b0};
            rd_hi_d = 1'b1;
            ph_d = PhWait;
          end
          PhWait: begin
            ram_raddr = {step_q[3:0], 1'b1};
            if (rd_hi_q) begin
              rk_d[127:64] = ram_rdata;
              rd_hi_d = 1'b0;
            end else begin
              rk_d[63:0] = ram_rdata;
              ph_d = PhLoad;
            end
          end
          PhLoad: begin
            if (step_q == 5'(kbe_pkg::RoundCount - 1)) begin
              v_d = v_q ^ rk_q;
              state_d = kbe_pkg::StOut;
            end else begin
              lctrl.load = 1'b1;
              load_val = sub_all(v_q ^ rk_q);
              shift_d = '0;
              ph_d = PhShift;
            end
          end
          PhShift: begin
            lctrl.step = 1'b1;
            shift_d = shift_q + 4'd1;
            if (shift_q == 4'(kbe_pkg::LinSteps - 1)) ph_d = PhDone;
          end
          PhDone: begin
            v_d = chain_val;
            step_d = step_q + 5'd1;
            ph_d = PhRead;
          end
          default: ph_d = PhRead;
        endcase
      end

      kbe_pkg::StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = kbe_pkg::StIdle;
        end
      end

      default: state_d = kbe_pkg::StIdle;
    endcase

    // Key writes invalidate the expanded keys.
    if (cfg_we_i) keys_ready_d = 1'b0;
  end

  assign cipher_high_o = v_q[127:64];
  assign cipher_low_o  = v_q[63:0];

  `KBE_ASSERT_IMPL(a_out_only_done, out_valid_o, state_q == kbe_pkg::StOut)
  `KBE_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(v_q))
  `KBE_ASSERT_NEXT(a_crypt_ready, in_acc && keys_ready_q, state_q == kbe_pkg::StCrypt)
  `KBE_ASSERT_NEXT(a_idle_after_out, out_acc, state_q == kbe_pkg::StIdle)

endmodule

// ----- rtl/kbe_ram.sv -----
module kbe_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 20
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/kbe_cell.sv -----
// One byte cell of the L shift chain: holds a byte, forwards it to the
// lower neighbor and adds its weighted share to the feedback term.
module kbe_cell (
  input  logic              clk_i,
  input  kbe_pkg::lin_ctrl_t ctrl_i,
  input  logic [3:0]        pos_i,
  input  kbe_pkg::byte_t    load_i,
  input  kbe_pkg::byte_t    shift_i,
  output kbe_pkg::byte_t    byte_o,
  output kbe_pkg::byte_t    term_o
);

  kbe_pkg::byte_t byte_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      byte_q <= load_i;
    end else if (ctrl_i.step) begin
      byte_q <= shift_i;
    end
  end

  assign byte_o = byte_q;
  assign term_o = kbe_pkg::gf_mul(byte_q, kbe_pkg::lin_coef(pos_i));

endmodule

// ----- rtl/kbe_chain.sv -----
// Sixteen byte cells in a row: one LFSR step of L per cycle while step is asserted.
module kbe_chain (
  input  logic               clk_i,
  input  kbe_pkg::lin_ctrl_t ctrl_i,
  input  kbe_pkg::blk_t      load_i,
  output kbe_pkg::blk_t      value_o
);

  kbe_pkg::byte_t cur [kbe_pkg::NumBytes];
  kbe_pkg::byte_t term [kbe_pkg::NumBytes];
  kbe_pkg::byte_t nxt [kbe_pkg::NumBytes];
  kbe_pkg::byte_t fb;

  always_comb begin
    fb = 8'h00;
    for (int k = 0; k < kbe_pkg::NumBytes; k++) fb = fb ^ term[k];
  end

  for (genvar k = 0; k < kbe_pkg::NumBytes; k++) begin : g_cell
    if (k == kbe_pkg::NumBytes - 1) begin : g_top
      assign nxt[k] = fb;
    end else begin : g_mid
      assign nxt[k] = cur[k+1];
    end
    kbe_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl_i),
      .pos_i  (4'(k)),
      .load_i (load_i[8*k +: 8]),
      .shift_i(nxt[k]),
      .byte_o (cur[k]),
      .term_o (term[k])
    );
    assign value_o[8*k +: 8] = cur[k];
  end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Substitution table, byte 0 first.
  localparam logic [0:255][7:0] PiTable = {
    8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
    8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
    8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
    8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
    8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
    8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
    8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
    8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
    8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
    8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
    8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
    8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
    8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
    8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
    8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
    8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6
  };

  localparam logic [0:15][7:0] MixCoef = {
    8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
    8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148
  };

  class cipher_scoreboard;
    logic [63:0]  key_words [4];
    logic [127:0] sched_keys [kbe_pkg::RoundCount];
    bit           sched_valid;
    logic [127:0] cipher_q [$];
    int unsigned  errors;
    int unsigned  blocks_seen;
    int unsigned  rekeys;

    function new();
      foreach (key_words[i]) key_words[i] = '0;
      sched_valid = 0;
      errors      = 0;
      blocks_seen = 0;
      rekeys      = 0;
    endfunction

    static function logic [7:0] field_mul(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      logic [8:0] x;
      acc = '0;
      x   = {1'b0, a};
      for (int n = 0; n < 8; n++) begin
        if (b[n]) acc ^= x[7:0];
        x = x << 1;
        if (x[8]) x ^= 9'h1C3;
      end
      return acc;
    endfunction

    static function logic [127:0] mix_bytes(logic [127:0] v);
      logic [7:0] fb;
      for (int s = 0; s < 16; s++) begin
        fb = '0;
        for (int k = 0; k < 16; k++) fb ^= field_mul(v[8*k +: 8], MixCoef[k]);
        v = {fb, v[127:8]};
      end
      return v;
    endfunction

    static function logic [127:0] sub_bytes(logic [127:0] v);
      for (int k = 0; k < 16; k++) v[8*k +: 8] = PiTable[v[8*k +: 8]];
      return v;
    endfunction

    function void set_key(kbe_pkg::reg_idx_t idx, logic [63:0] val);
      key_words[idx] = val;
      sched_valid    = 0;
    endfunction

    function void build_schedule();
      logic [127:0] a1, a0, c, t;
      a1 = {key_words[kbe_pkg::RegKey0], key_words[kbe_pkg::RegKey1]};
      a0 = {key_words[kbe_pkg::RegKey2], key_words[kbe_pkg::RegKey3]};
      sched_keys[0] = a1;
      sched_keys[1] = a0;
      for (int p = 1; p < 5; p++) begin
        for (int j = 1; j <= 8; j++) begin
          c  = mix_bytes(128'(8 * (p - 1) + j));
          t  = a1;
          a1 = mix_bytes(sub_bytes(a1 ^ c)) ^ a0;
          a0 = t;
        end
        sched_keys[2*p]   = a1;
        sched_keys[2*p+1] = a0;
      end
      sched_valid = 1;
      rekeys++;
    endfunction

    function void note_plain(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] v;
      if (!sched_valid) build_schedule();
      v = {hi, lo};
      for (int r = 0; r < kbe_pkg::RoundCount - 1; r++) begin
        v = mix_bytes(sub_bytes(v ^ sched_keys[r]));
      end
      cipher_q = {cipher_q, v ^ sched_keys[kbe_pkg::RoundCount-1]};
      blocks_seen++;
    endfunction

    function void check_cipher(logic [63:0] hi, logic [63:0] lo);
      logic [127:0] want;
      if (cipher_q.size() == 0) begin
        $display("%0t: unexpected cipher block %h_%h", $time, hi, lo);
        errors++;
        return;
      end
      want = cipher_q.pop_front();
      if (hi !== want[127:64]) begin
        $display("%0t: cipher_high expected %h actual %h", $time, want[127:64], hi);
        errors++;
      end
      if (lo !== want[63:0]) begin
        $display("%0t: cipher_low expected %h actual %h", $time, want[63:0], lo);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [63:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [63:0] plain_high_i;
  logic [63:0] plain_low_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [63:0] cipher_high_o;
  logic [63:0] cipher_low_o;

  cipher_scoreboard sb = new();
  bit hold_req = 0;
  int unsigned stall_mode = 0;

  kuznyechik_block_encrypt_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("tb_top: done, errors");
    $finish;
  end

  // Receiver: stall on its own pattern, plus one long hold-off on request.
  initial begin
    int unsigned left;
    out_stall_i = 1'b0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        for (int n = 0; n < 600; n++) @(negedge clk_i);
        hold_req = 0;
      end
      if (left == 0) begin
        stall_mode = $urandom_range(0, 3);
        left = $urandom_range(20, 400);
      end
      left--;
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 8);
        default: out_stall_i <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_cipher(cipher_high_o, cipher_low_o);
  end

  int unsigned burst_left = 0;

  // Offer one request; return at the falling edge after it was taken.
  task automatic send_block(logic [63:0] hi, logic [63:0] lo);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 10);
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid_i   <= 1'b0;
        plain_high_i <= {$urandom(), $urandom()};
        for (int n = 0; n < gap; n++) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    plain_high_i <= hi;
    plain_low_i  <= lo;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_plain(hi, lo);
    @(negedge clk_i);
  endtask

  task automatic drain();
    int unsigned n;
    in_valid_i <= 1'b0;
    while (sb.cipher_q.size() != 0) @(posedge clk_i);
    n = 0;
    while (n < 200) begin
      @(negedge clk_i);
      n++;
    end
  endtask

  task automatic write_key(kbe_pkg::reg_idx_t idx, logic [63:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    sb.set_key(idx, val);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic write_all_keys(logic [63:0] k0, logic [63:0] k1,
                                logic [63:0] k2, logic [63:0] k3);
    write_key(kbe_pkg::RegKey0, k0);
    write_key(kbe_pkg::RegKey1, k1);
    write_key(kbe_pkg::RegKey2, k2);
    write_key(kbe_pkg::RegKey3, k3);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 64'd1 << $urandom_range(0, 63);
      1: return ~(64'd1 << $urandom_range(0, 63));
      2: return $urandom_range(0, 1) ? '1 : '0;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic send_random(int unsigned count);
    for (int i = 0; i < count; i++) send_block(rand_word(), rand_word());
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    in_valid_i   = 1'b0;
    plain_high_i = '0;
    plain_low_i  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // All-zero key left from reset.
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h8000_0000_0000_0000, 64'h1);
    send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    drain();

    // Standard test key and block.
    write_all_keys(64'h8899AABBCCDDEEFF, 64'h0011223344556677,
                   64'hFEDCBA9876543210, 64'h0123456789ABCDEF);
    send_block(64'h1122334455667700, 64'hFFEEDDCCBBAA9988);
    send_block('0, '1);
    send_block('1, '0);
    send_block(64'h0000_0000_0000_0080, 64'h0000_0000_0000_0100);
    drain();

    write_all_keys('1, '1, '1, '1);
    send_block('0, '0);
    send_block('1, '1);
    send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
    drain();

    // Change one word only: the schedule must be rebuilt.
    write_key(kbe_pkg::RegKey2, '0);
    send_block('0, '0);
    send_block(64'h8000, 64'h80);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 3) write_key(kbe_pkg::reg_idx_t'($urandom_range(0, 3)), rand_word());
      else write_all_keys(rand_word(), rand_word(), rand_word(), rand_word());
      if (ph == 2) begin
        send_random(10);
        hold_req = 1;
      end
      send_random(260);
      drain();
    end

    $display("tb_top: %0d blocks checked under %0d key schedules",
             sb.blocks_seen, sb.rekeys);
    $display("tb_top: directed extremes, standard test vector, random keys and data");
    if (sb.errors == 0 && sb.cipher_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
